// ===== src/ild_pkg.sv =====
// Shared types and constants for the idle-based CPU load estimator.
package ild_pkg;

  localparam int CEIL_W = 48;          // idle ceiling, unsigned Q32.16
  localparam int ACC_W  = CEIL_W + 2;  // accumulator / partial remainder width
  localparam int FRAC_W = 16;          // Q0.16 fraction bits
  localparam int LOAD_W = FRAC_W + 1;  // load spans 0..1.0 inclusive

  localparam logic [LOAD_W-1:0] Q16_ONE     = LOAD_W'(65536);
  localparam logic [15:0]       ALPHA_RESET = 16'd6554;

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } ild_op_t;

  typedef struct packed {
    logic    start;
    ild_op_t op;
  } ild_cmd_t;

endpackage

// ===== src/idle_based_cpu_load_estimator.sv =====
// Top level of the idle-based CPU load estimator: sequencer, state and stream ports.
//
// Each transfer on the slave side carries one sample of a free-running idle
// counter; the block answers with one result carrying the load in Q0.16
// (65536 = fully busy), the wrapped idle delta and a calibrated flag. The first
// nonzero delta seeds the idle ceiling; later nonzero deltas blend into it with
// weight smoothing_alpha (Q0.16, written through cfg_wr_en / cfg_wr_data; the
// user must write it only while the block is idle, and the block itself does
// not enforce this). A sample passes through update, an optional moving-average
// step, load, an optional load division and emit; the shared shift-add / shift-
// subtract unit retires one bit per cycle while it runs, for the moving-average
// product and the load quotient. s_axis_tready is high only while the sequencer
// waits for a sample; a result held in the output register does not block the
// next one from being accepted, only from being sent.
module idle_based_cpu_load_estimator
  import ild_pkg::*;
#(
  parameter int COUNTER_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,    // smoothing_alpha
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] idle_count
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata    // [16:0] load, [48:17] idle_delta,
                                      // [49] calibrated, [55:50] zero
);

  localparam int EW = (COUNTER_WIDTH > 32) ? COUNTER_WIDTH : 32;
  localparam logic [EW-1:0] CNT_MASK = EW'(((65'd1) << COUNTER_WIDTH) - 65'd1);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_UPD  = 6'b000010,
    ST_MUL  = 6'b000100,
    ST_LOAD = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_EMIT = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  logic [15:0]       smoothing_alpha;
  logic [31:0]       previous_idle;
  logic [CEIL_W-1:0] idle_ceiling;
  logic              ceiling_seeded;

  logic [31:0]       idle_delta;
  logic [CEIL_W-1:0] dq;
  logic              delta_nz;
  logic [LOAD_W-1:0] load_q16;

  logic [EW-1:0]     cur_ext;
  logic [EW-1:0]     d_full;
  logic              d_big;

  ild_cmd_t          cmd;
  logic              arith_done;
  logic [CEIL_W-1:0] product;
  logic [FRAC_W-1:0] quotient;
  logic              can_emit;
  logic              need_div;

  assign cur_ext = EW'(s_axis_tdata) & CNT_MASK;
  assign d_full  = (cur_ext - EW'(previous_idle)) & CNT_MASK;
  assign d_big   = (d_full >> 32) != '0;

  assign s_axis_tready = (state == ST_IDLE);
  assign can_emit      = !m_axis_tvalid || m_axis_tready;
  assign need_div      = (idle_ceiling != '0) && (dq < idle_ceiling);

  always_comb begin
    state_next = state;
    cmd.start  = 1'b0;
    cmd.op     = OP_MUL;
    unique case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) state_next = ST_UPD;
      end
      ST_UPD: begin
        if (delta_nz && ceiling_seeded && (smoothing_alpha != '0)) begin
          cmd.start  = 1'b1;
          state_next = ST_MUL;
        end else begin
          state_next = ST_LOAD;
        end
      end
      ST_MUL: begin
        if (arith_done) state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (need_div) begin
          cmd.start  = 1'b1;
          cmd.op     = OP_DIV;
          state_next = ST_DIV;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_DIV: begin
        if (arith_done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        // Hold the result until the output register is free.
        if (can_emit) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      smoothing_alpha <= ALPHA_RESET;
      previous_idle   <= '0;
      idle_ceiling    <= '0;
      ceiling_seeded  <= 1'b0;
      m_axis_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) smoothing_alpha <= cfg_wr_data;

      if (state == ST_EMIT && can_emit) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) previous_idle <= cur_ext[31:0];
        end
        ST_UPD: begin
          if (delta_nz && !ceiling_seeded) begin
            idle_ceiling   <= dq;
            ceiling_seeded <= 1'b1;
          end
        end
        ST_MUL: begin
          if (arith_done) idle_ceiling <= product;
        end
        ST_LOAD: ;
        ST_DIV: ;
        ST_EMIT: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_axis_tvalid) begin
      idle_delta <= d_full[31:0];
      delta_nz   <= d_full != '0;
      dq         <= d_big ? '1 : {d_full[31:0], 16'h0000};
    end
    if (state == ST_LOAD && !need_div) begin
      load_q16 <= (idle_ceiling == '0) ? Q16_ONE : LOAD_W'(0);
    end
    if (state == ST_DIV && arith_done) begin
      load_q16 <= Q16_ONE - LOAD_W'(quotient);
    end
    if (state == ST_EMIT && can_emit) begin
      m_axis_tdata <= {6'b0, ceiling_seeded, idle_delta, load_q16};
    end
  end

  ild_arith u_arith (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .alpha    (smoothing_alpha),
    .dq       (dq),
    .ceil     (idle_ceiling),
    .done     (arith_done),
    .product  (product),
    .quotient (quotient)
  );

endmodule

// ===== src/ild_arith.sv =====
// Shared shift-add / shift-subtract unit: ceiling average and load division.
module ild_arith import ild_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  ild_cmd_t            cmd,
  input  logic [15:0]         alpha,
  input  logic [CEIL_W-1:0]   dq,
  input  logic [CEIL_W-1:0]   ceil,
  output logic                done,
  output logic [CEIL_W-1:0]   product,
  output logic [FRAC_W-1:0]   quotient
);

  logic [ACC_W-1:0]  acc;
  logic [FRAC_W-1:0] quo;
  logic [3:0]        step;
  logic              busy;
  ild_op_t           op;

  logic [15:0]       beta;
  logic [ACC_W-1:0]  pp;
  logic [ACC_W-1:0]  base;
  logic [ACC_W-1:0]  addend;
  logic              cin;
  logic [ACC_W:0]    total;

  // Weight of the old ceiling; alpha of zero never reaches this unit.
  assign beta = 16'(Q16_ONE - LOAD_W'(alpha));

  always_comb begin
    pp = ACC_W'(alpha[step] ? dq : '0) + ACC_W'(beta[step] ? ceil : '0);
    if (op == OP_MUL) begin
      base   = acc;
      addend = pp;
      cin    = 1'b0;
    end else begin
      base   = {acc[ACC_W-2:0], 1'b0};
      addend = ~ACC_W'(ceil);
      cin    = 1'b1;
    end
    total = {1'b0, base} + {1'b0, addend} + (ACC_W + 1)'(cin);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 4'd1;
        if (step == 4'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op  <= cmd.op;
      acc <= (cmd.op == OP_MUL) ? '0 : ACC_W'(dq);
      quo <= '0;
    end else if (busy) begin
      if (op == OP_MUL) begin
        // Right-shifting accumulation drops the low 16 bits exactly as truncation.
        acc <= total[ACC_W:1];
      end else if (total[ACC_W]) begin
        // No borrow: shifted remainder covers the ceiling, subtract and set bit.
        acc <= total[ACC_W-1:0];
        quo <= {quo[FRAC_W-2:0], 1'b1};
      end else begin
        acc <= base;
        quo <= {quo[FRAC_W-2:0], 1'b0};
      end
    end
  end

  assign product  = acc[CEIL_W-1:0];
  assign quotient = quo;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the idle-based CPU load estimator.
`timescale 1ns / 100ps

module tb_top import ild_pkg::*; ();

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int LONG_HOLD       = 300;
  localparam int ITEMS_PER_PHASE = 155;

  typedef struct {
    logic [LOAD_W-1:0] load_q16;
    logic [31:0]       idle_delta;
    logic              calibrated;
  } load_result_t;

  // Predicts every load result from accepted samples and checks the outputs in order.
  class load_scoreboard;
    bit [15:0]       alpha;
    bit [31:0]       prev_idle;
    bit [CEIL_W-1:0] ceiling;
    bit              seeded;
    load_result_t    expected_loads[$];
    int              errors;

    function new();
      alpha     = ALPHA_RESET;
      prev_idle = '0;
      ceiling   = '0;
      seeded    = 1'b0;
      errors    = 0;
    endfunction

    function void set_alpha(bit [15:0] a);
      alpha = a;
    endfunction

    function int pending();
      return expected_loads.size();
    endfunction

    function void note_sample(bit [31:0] idle_count);
      bit [31:0]       delta;
      bit [CEIL_W-1:0] delta_q;
      bit [63:0]       sum;
      bit [63:0]       frac;
      load_result_t    r;
      delta   = idle_count - prev_idle;
      delta_q = {delta, 16'h0000};
      // A zero delta leaves the ceiling alone and never seeds it
      if (delta != 0) begin
        if (!seeded) begin
          ceiling = delta_q;
          seeded  = 1'b1;
        end else begin
          sum = (64'd65536 - 64'(alpha)) * 64'(ceiling) + 64'(alpha) * 64'(delta_q);
          ceiling = sum[63:16];
        end
      end
      if (ceiling == 0) begin
        r.load_q16 = Q16_ONE;
      end else if (delta_q >= ceiling) begin
        r.load_q16 = '0;
      end else begin
        frac = {delta_q, 16'h0000} / 64'(ceiling);
        r.load_q16 = Q16_ONE - frac[LOAD_W-1:0];
      end
      r.idle_delta = delta;
      r.calibrated = seeded;
      prev_idle = idle_count;
      expected_loads.push_back(r);
    endfunction

    function void check_result(logic [55:0] tdata);
      load_result_t exp_r;
      if (expected_loads.size() == 0) begin
        $error("result 0x%h arrived with no sample waiting", tdata);
        errors++;
        return;
      end
      exp_r = expected_loads.pop_front();
      if (tdata[16:0] !== exp_r.load_q16) begin
        $error("load: expected %0d, actual %0d", exp_r.load_q16, tdata[16:0]);
        errors++;
      end
      if (tdata[48:17] !== exp_r.idle_delta) begin
        $error("idle_delta: expected 0x%h, actual 0x%h", exp_r.idle_delta, tdata[48:17]);
        errors++;
      end
      if (tdata[49] !== exp_r.calibrated) begin
        $error("calibrated: expected %0d, actual %0d", exp_r.calibrated, tdata[49]);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [31:0] idle_count
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;   // [16:0] load, [48:17] idle_delta, [49] calibrated

  load_scoreboard sb;
  bit        no_idle        = 1'b0;
  int        long_hold_req  = 0;
  int        long_hold_seen = 0;
  int        stall_left     = 0;
  int        cycle_count    = 0;
  bit [31:0] last_sent      = '0;
  bit [31:0] base_delta     = 32'd1000;

  idle_based_cpu_load_estimator DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones
  function automatic int idle_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver: check each result transfer, then pick the next ready level
  always @(posedge clk) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    if (long_hold_req != long_hold_seen) begin
      long_hold_seen = long_hold_req;
      stall_left     = LONG_HOLD;
    end
    if (stall_left == 0) stall_left = idle_gap();
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  function automatic bit [31:0] pick_base();
    case ($urandom_range(3))
      0:       return $urandom_range(1, 255);
      1:       return $urandom_range(256, 65535);
      2:       return $urandom_range(32'h0001_0000, 32'h00FF_FFFF);
      default: return $urandom_range(32'h0100_0000, 32'hFFFF_FFFF);
    endcase
  endfunction

  // Mostly a steady tick of idle counts with jitter; the rest zero deltas,
  // tiny deltas, idle spikes and raw noise
  function automatic bit [31:0] next_sample();
    int        r;
    bit [31:0] step;
    if ($urandom_range(99) < 4) base_delta = pick_base();
    r = $urandom_range(99);
    if (r < 65) begin
      step = base_delta - (base_delta >> 3) + $urandom_range(0, base_delta >> 2);
    end else if (r < 75) begin
      step = '0;
    end else if (r < 85) begin
      return $urandom();
    end else if (r < 92) begin
      step = $urandom_range(1, 3);
    end else begin
      step = base_delta * $urandom_range(2, 4);
    end
    return last_sent + step;
  endfunction

  task automatic send_sample(input bit [31:0] v);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_sample(v);
    last_sent = v;
  endtask

  // Drain all pending results, then write the register while the block is idle
  task automatic write_alpha(input bit [15:0] a);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= a;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_alpha(a);
  endtask

  initial begin
    bit [15:0] phase_alpha[7];
    sb = new();
    rst           <= 1'b1;
    cfg_wr_en     <= 1'b0;
    cfg_wr_data   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset weight: zero deltas before seeding, seeding, wrap, huge delta
    send_sample(32'h0000_0000);
    send_sample(32'h0000_0000);
    send_sample(32'd1000);
    send_sample(32'd1000);
    send_sample(32'd1500);
    send_sample(32'd3000);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'h0000_0005);
    send_sample(32'h8000_0000);
    // Zero weight: ceiling must hold
    write_alpha(16'h0000);
    send_sample(32'h8000_1000);
    send_sample(32'h8000_2000);
    send_sample(32'h8000_2800);
    send_sample(32'h8000_2800);
    // Full weight
    write_alpha(16'hFFFF);
    send_sample(32'h8000_3000);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'h0000_0000);
    write_alpha(16'h0001);
    send_sample(32'h0000_0001);
    send_sample(32'h0000_0003);
    send_sample(32'h0000_0004);

    phase_alpha = '{16'h8000, ALPHA_RESET, 16'hFFFF, 16'h0000, 16'h0001,
                    16'($urandom()), 16'($urandom())};
    for (int p = 0; p < 7; p++) begin
      write_alpha(phase_alpha[p]);
      no_idle    = (p == 2);
      base_delta = pick_base();
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // Hold the receiver off long enough for the block to back up its input
        if (p == 0 && i == 40) long_hold_req++;
        send_sample(next_sample());
      end
    end
    no_idle = 1'b0;

    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
